FILE: hw/rtl/quaternion_to_axis_angle_defines.svh
// ----------------------------------------------------------------------------
// Quaternion to axis-angle: assertion macros
// Shared wrappers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_AXIS_ANGLE_DEFINES_SVH
`define QUATERNION_TO_AXIS_ANGLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define Q2A_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define Q2A_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/q2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2a_pkg
// Types, constants and helper functions shared by the quaternion to
// axis-angle converter.
// ----------------------------------------------------------------------------
package q2a_pkg;

    // Default component width of the quaternion and axis fields.
    localparam int CW_DEFAULT = 16;

    // Angle result, unsigned Q3.13 radians.
    localparam int ANGLE_W   = 16;
    localparam int ANGLE_MAX = 51472;
    localparam int ANG_T_W   = ANGLE_W + 1;
    localparam int ANG_SH    = 13;

    // Zero-length threshold register.
    localparam int EPS_W     = 15;
    localparam int EPS_RESET = 16;

    // Cosine series arithmetic.
    localparam int COS_FRAC  = 28;
    localparam int COS_TERMS = 16;
    localparam int COS_TW    = 36;
    localparam int COS_XW    = ANG_T_W + ANG_SH;
    localparam int COS_SW    = 40;
    localparam int COS_HW    = COS_TW / 2;
    localparam int COS_DW    = 10;
    localparam int COS_STAGES = 5;
    localparam int COS_LAT   = COS_TERMS * COS_STAGES;

    // Binary search over the angle code.
    localparam int SEARCH_STEPS = 16;
    localparam int STEP_LAT     = COS_LAT + 1;
    localparam int ANG_LAT      = 1 + SEARCH_STEPS * STEP_LAT;

    typedef logic [ANGLE_W-1:0] angle_t;
    typedef logic [EPS_W-1:0]   eps_t;

    // floor(2^36 / ((2n-1)*2n)) for n = 1..16.
    localparam logic [COS_TW-1:0] COS_RECIP [COS_TERMS] = '{
        36'd34359738368, 36'd5726623061, 36'd2290649224, 36'd1227133513,
        36'd763549741,   36'd520602096,  36'd377579542,  36'd286331153,
        36'd224573453,   36'd180840728,  36'd148743456,  36'd124491805,
        36'd105722271,   36'd90898778,   36'd78987904,   36'd69273666
    };

    // Divisor of the n-th series term.
    function automatic int cos_div(input int n);
        return (2 * n - 1) * (2 * n);
    endfunction

    // Cycles through the axis unit.
    function automatic int ax_latency(input int cw);
        return cw + 3;
    endfunction

endpackage

FILE: hw/rtl/quaternion_to_axis_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_axis_angle
// Converts a Q1.14 quaternion into a unit axis and a Q3.13 rotation angle.
// ----------------------------------------------------------------------------
// Usage:
// A quaternion beat enters on s_axis (x, y, z, w from the low bits up) and
// one result beat leaves on m_axis: axis x, y, z and angle in tdata, the
// degenerate flag in tuser. While the receiver does not stall, a beat can be
// accepted in every cycle, so the sustained rate is one quaternion per clock.
// The delay from an accepted input beat to its result beat is set by the angle
// search: 16 steps, each waiting on a cosine unit of 80 stages (five per
// series term) plus one compare stage, behind the input and clamp registers.
// The axis path is shorter and is delayed to line up with the angle.
// cfg_wr_en writes zero_length_epsilon; write it only while no beat is in
// flight. Reset clears all valid bits and sets the threshold to 16.
// When the receiver stalls, the whole pipeline holds and s_axis_tready
// drops; nothing is lost or repeated. The output register is reloaded in
// the same cycle it is taken, so a beat can follow every cycle.
// ----------------------------------------------------------------------------
module quaternion_to_axis_angle
    import q2a_pkg::*;
#(
    parameter int COMPONENT_WIDTH = CW_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  eps_t                   cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w
    input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // axis_x, axis_y, axis_z, angle
    output logic [((3*COMPONENT_WIDTH+ANGLE_W+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic                   m_axis_tuser
);

    localparam int CW     = COMPONENT_WIDTH;
    localparam int OUT_W  = ((3 * CW + ANGLE_W + 7) / 8) * 8;
    localparam int AX_LAT = ax_latency(CW);
    localparam int TOTAL  = ANG_LAT + 2;
    localparam int AXD_W  = 3 * CW + 1;

    logic                 adv;
    logic [TOTAL-1:0]     vld_reg, vld_next;
    eps_t                 eps_reg;
    logic signed [CW-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [CW-1:0] ax_x, ax_y, ax_z;
    logic                 ax_deg;
    logic [AXD_W-1:0]     axd;
    angle_t               ang;
    logic signed [CW-1:0] ox_reg, oy_reg, oz_reg;
    angle_t               oang_reg;
    logic                 odeg_reg;

    // The pipeline advances whenever the output register is free or taken.
    assign adv           = !vld_reg[TOTAL-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign vld_next      = {vld_reg[TOTAL-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= eps_t'(EPS_RESET);
        end
        else if (cfg_wr_en)
        begin
            eps_reg <= cfg_wr_data;
        end
    end

    // Input beat register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg <= signed'(s_axis_tdata[0 +: CW]);
            qy_reg <= signed'(s_axis_tdata[CW +: CW]);
            qz_reg <= signed'(s_axis_tdata[2*CW +: CW]);
            qw_reg <= signed'(s_axis_tdata[3*CW +: CW]);
        end
    end

    q2a_axis #(
        .COMPONENT_WIDTH (CW)
    ) u_axis (
        .clk        (clk),
        .en         (adv),
        .x_in       (qx_reg),
        .y_in       (qy_reg),
        .z_in       (qz_reg),
        .eps        (eps_reg),
        .axis_x     (ax_x),
        .axis_y     (ax_y),
        .axis_z     (ax_z),
        .degenerate (ax_deg)
    );

    q2a_delay #(
        .WIDTH (AXD_W),
        .DEPTH (ANG_LAT - AX_LAT)
    ) u_axis_dly (
        .clk  (clk),
        .en   (adv),
        .din  ({ax_deg, ax_z, ax_y, ax_x}),
        .dout (axd)
    );

    q2a_angle #(
        .COMPONENT_WIDTH (CW)
    ) u_angle (
        .clk       (clk),
        .en        (adv),
        .w_in      (qw_reg),
        .angle_out (ang)
    );

    // Output register; a degenerate beat reports a zero angle.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg   <= signed'(axd[0 +: CW]);
            oy_reg   <= signed'(axd[CW +: CW]);
            oz_reg   <= signed'(axd[2*CW +: CW]);
            odeg_reg <= axd[3*CW];
            oang_reg <= axd[3*CW] ? '0 : ang;
        end
    end

    assign m_axis_tvalid = vld_reg[TOTAL-1];
    assign m_axis_tdata  = OUT_W'({oang_reg, oz_reg, oy_reg, ox_reg});
    assign m_axis_tuser  = odeg_reg;

endmodule

FILE: hw/rtl/q2a_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2a_delay
// Enabled shift line that carries a payload word alongside a pipeline.
// ----------------------------------------------------------------------------
module q2a_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift one place per advancing cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

FILE: hw/rtl/q2a_cos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2a_cos
// Pipelined cosine by a 16-term Taylor series in Q28, five stages per term.
// ----------------------------------------------------------------------------
module q2a_cos
    import q2a_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [ANG_T_W-1:0]       t_in,
    output logic signed [COS_SW-1:0] cos_out
);

    logic [COS_XW-1:0]        x_chain    [COS_TERMS+1];
    logic [COS_TW-1:0]        term_chain [COS_TERMS+1];
    logic signed [COS_SW-1:0] sum_chain  [COS_TERMS+1];

    // Series seed: x = t scaled to Q28 radians, term = sum = 1.0.
    assign x_chain[0]    = {t_in, {ANG_SH{1'b0}}};
    assign term_chain[0] = COS_TW'(1) << COS_FRAC;
    assign sum_chain[0]  = COS_SW'(1) << COS_FRAC;

    for (genvar n = 1; n <= COS_TERMS; n++)
    begin : g_term
        localparam logic [COS_TW-1:0] RECIP = COS_RECIP[n-1];
        localparam logic [COS_DW-1:0] DIV   = COS_DW'(cos_div(n));
        localparam bit                NEG   = (n % 2) == 1;

        logic [COS_TW+COS_XW-1:0] p1, p2;
        logic [2*COS_TW-1:0]      prod;
        logic [COS_TW+COS_DW-1:0] qd;
        logic [COS_TW-1:0]        q0;
        logic [COS_TW-1:0]        q;

        logic [COS_TW-1:0]        t1_reg, t2_reg, v3_reg, q0_reg, rem_reg, q5_reg;
        logic [COS_HW+COS_TW-1:0] plo_reg, phi_reg;
        logic [COS_XW-1:0]        x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
        logic signed [COS_SW-1:0] s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;

        // Products, reciprocal division and correction.
        always_comb
        begin
            p1   = (COS_TW+COS_XW)'(term_chain[n-1]) * (COS_TW+COS_XW)'(x_chain[n-1]);
            p2   = (COS_TW+COS_XW)'(t1_reg) * (COS_TW+COS_XW)'(x1_reg);
            prod = ((2*COS_TW)'(phi_reg) << COS_HW) + (2*COS_TW)'(plo_reg);
            q0   = prod[COS_TW +: COS_TW];
            qd   = (COS_TW+COS_DW)'(q0) * (COS_TW+COS_DW)'(DIV);
            q    = q0_reg + COS_TW'(rem_reg >= COS_TW'(DIV));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t1_reg  <= p1[COS_FRAC +: COS_TW];
                x1_reg  <= x_chain[n-1];
                s1_reg  <= sum_chain[n-1];
                t2_reg  <= p2[COS_FRAC +: COS_TW];
                x2_reg  <= x1_reg;
                s2_reg  <= s1_reg;
                plo_reg <= (COS_HW+COS_TW)'(t2_reg[COS_HW-1:0]) * (COS_HW+COS_TW)'(RECIP);
                phi_reg <= (COS_HW+COS_TW)'(t2_reg[COS_TW-1:COS_HW]) * (COS_HW+COS_TW)'(RECIP);
                v3_reg  <= t2_reg;
                x3_reg  <= x2_reg;
                s3_reg  <= s2_reg;
                q0_reg  <= q0;
                rem_reg <= v3_reg - qd[COS_TW-1:0];
                x4_reg  <= x3_reg;
                s4_reg  <= s3_reg;
                q5_reg  <= q;
                x5_reg  <= x4_reg;
                s5_reg  <= NEG ? s4_reg - signed'(COS_SW'(q)) : s4_reg + signed'(COS_SW'(q));
            end
        end

        assign term_chain[n] = q5_reg;
        assign x_chain[n]    = x5_reg;
        assign sum_chain[n]  = s5_reg;
    end

    assign cos_out = sum_chain[COS_TERMS];

endmodule

FILE: hw/rtl/q2a_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2a_angle
// Angle code as twice the arccosine of w, by a pipelined binary search with
// one cosine unit per search step.
// ----------------------------------------------------------------------------
module q2a_angle
    import q2a_pkg::*;
#(
    parameter int COMPONENT_WIDTH = CW_DEFAULT
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [COMPONENT_WIDTH-1:0] w_in,
    output angle_t                     angle_out
);

    localparam int CW    = COMPONENT_WIDTH;
    localparam int FRAC  = CW - 2;
    localparam int CMP_W = COS_SW + CW;
    localparam int BW    = 3 * ANGLE_W + CW;
    localparam logic signed [CW-1:0] W_ONE  = CW'(1) << FRAC;
    localparam logic signed [CW-1:0] W_MONE = -W_ONE;

    logic signed [CW-1:0] wc_reg;
    angle_t               lo_s [SEARCH_STEPS+1];
    angle_t               hi_s [SEARCH_STEPS+1];
    logic signed [CW-1:0] w_s  [SEARCH_STEPS+1];

    // Clamp w to [-1, 1].
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (w_in > W_ONE)
            begin
                wc_reg <= W_ONE;
            end
            else if (w_in < W_MONE)
            begin
                wc_reg <= W_MONE;
            end
            else
            begin
                wc_reg <= w_in;
            end
        end
    end

    assign lo_s[0] = '0;
    assign hi_s[0] = angle_t'(ANGLE_MAX);
    assign w_s[0]  = wc_reg;

    for (genvar j = 0; j < SEARCH_STEPS; j++)
    begin : g_step
        logic [ANGLE_W:0]         mid_sum;
        angle_t                   mid;
        logic [ANG_T_W-1:0]       t_val;
        logic signed [COS_SW-1:0] cos_val;
        logic [BW-1:0]            bundle_dly;
        angle_t                   lo_d, hi_d, mid_d;
        logic signed [CW-1:0]     w_d;
        logic signed [CMP_W-1:0]  lhs, rhs;
        angle_t                   lo_reg, hi_reg;
        logic signed [CW-1:0]     w_reg;

        // Midpoint and the cosine argument 2*mid-1.
        always_comb
        begin
            mid_sum = (ANGLE_W+1)'(lo_s[j]) + (ANGLE_W+1)'(hi_s[j]) + (ANGLE_W+1)'(1);
            mid     = mid_sum[ANGLE_W:1];
            t_val   = {mid, 1'b0} - ANG_T_W'(1);
        end

        q2a_cos u_cos (
            .clk     (clk),
            .en      (en),
            .t_in    (t_val),
            .cos_out (cos_val)
        );

        q2a_delay #(
            .WIDTH (BW),
            .DEPTH (COS_LAT)
        ) u_dly (
            .clk  (clk),
            .en   (en),
            .din  ({mid, w_s[j], hi_s[j], lo_s[j]}),
            .dout (bundle_dly)
        );

        // Compare cos * 2^FRAC against w * 2^28 and narrow the range.
        always_comb
        begin
            lo_d  = bundle_dly[0 +: ANGLE_W];
            hi_d  = bundle_dly[ANGLE_W +: ANGLE_W];
            w_d   = signed'(bundle_dly[2*ANGLE_W +: CW]);
            mid_d = bundle_dly[2*ANGLE_W+CW +: ANGLE_W];
            lhs   = CMP_W'(cos_val) <<< FRAC;
            rhs   = CMP_W'(w_d) <<< COS_FRAC;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                w_reg <= w_d;
                if (lo_d < hi_d && lhs >= rhs)
                begin
                    lo_reg <= mid_d;
                    hi_reg <= hi_d;
                end
                else if (lo_d < hi_d)
                begin
                    lo_reg <= lo_d;
                    hi_reg <= mid_d - angle_t'(1);
                end
                else
                begin
                    lo_reg <= lo_d;
                    hi_reg <= hi_d;
                end
            end
        end

        assign lo_s[j+1] = lo_reg;
        assign hi_s[j+1] = hi_reg;
        assign w_s[j+1]  = w_reg;
    end

    assign angle_out = lo_s[SEARCH_STEPS];

endmodule

FILE: hw/rtl/q2a_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2a_axis
// Squared length, zero-length test and a bit-per-stage search for each
// normalized axis component, rounded to nearest.
// ----------------------------------------------------------------------------
module q2a_axis
    import q2a_pkg::*;
#(
    parameter int COMPONENT_WIDTH = CW_DEFAULT
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [COMPONENT_WIDTH-1:0] x_in,
    input  logic signed [COMPONENT_WIDTH-1:0] y_in,
    input  logic signed [COMPONENT_WIDTH-1:0] z_in,
    input  eps_t                              eps,
    output logic signed [COMPONENT_WIDTH-1:0] axis_x,
    output logic signed [COMPONENT_WIDTH-1:0] axis_y,
    output logic signed [COMPONENT_WIDTH-1:0] axis_z,
    output logic                              degenerate
);

    localparam int CW    = COMPONENT_WIDTH;
    localparam int FRAC  = CW - 2;
    localparam int SW    = 2 * CW;
    localparam int AW    = 4 * CW + 4;
    localparam int QW    = FRAC + 1;
    localparam int DEG_W = (SW > 2 * EPS_W) ? SW : 2 * EPS_W;

    logic signed [CW-1:0] comp_in [3];
    logic [CW-1:0]        mag_reg [3];
    logic                 neg1_reg [3];
    logic [2*EPS_W-1:0]   eps2_reg, eps2b_reg;
    logic [SW-1:0]        sq_reg [3];
    logic                 neg2_reg [3];
    logic [SW-1:0]        s_sum;

    // Search pipeline, index 0 is the setup stage.
    logic signed [AW-1:0] d2_s  [FRAC+2][3];
    logic signed [AW-1:0] ds_s  [FRAC+2][3];
    logic signed [AW-1:0] r_s   [FRAC+2][3];
    logic [QW-1:0]        q_s   [FRAC+2][3];
    logic                 neg_s [FRAC+2][3];
    logic [SW-1:0]        s_s   [FRAC+2];
    logic                 deg_s [FRAC+2];

    logic signed [CW-1:0] axis_reg [3];
    logic                 deg_reg;

    assign comp_in[0] = x_in;
    assign comp_in[1] = y_in;
    assign comp_in[2] = z_in;

    // Magnitudes and squares, then the squared length and threshold test.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                mag_reg[l]  <= comp_in[l][CW-1] ? CW'(-comp_in[l]) : CW'(comp_in[l]);
                neg1_reg[l] <= comp_in[l][CW-1];
                sq_reg[l]   <= SW'(mag_reg[l]) * SW'(mag_reg[l]);
                neg2_reg[l] <= neg1_reg[l];
            end
            eps2_reg  <= (2*EPS_W)'(eps) * (2*EPS_W)'(eps);
            eps2b_reg <= eps2_reg;
        end
    end

    assign s_sum = sq_reg[0] + sq_reg[1] + sq_reg[2];

    // Setup: d = -1 gives d^2*S = S and d*S = -S.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_s[0]   <= s_sum;
            deg_s[0] <= DEG_W'(s_sum) <= DEG_W'(eps2b_reg);
            for (int l = 0; l < 3; l++)
            begin
                d2_s[0][l]  <= signed'(AW'(s_sum));
                ds_s[0][l]  <= -signed'(AW'(s_sum));
                r_s[0][l]   <= signed'(AW'(sq_reg[l]) << (2 * FRAC + 2));
                q_s[0][l]   <= '0;
                neg_s[0][l] <= neg2_reg[l];
            end
        end
    end

    // One result bit per stage: keep q + 2^b while (2q-1)^2 * S <= a^2 * 2^(2F+2).
    for (genvar k = 0; k <= FRAC; k++)
    begin : g_bit
        localparam int B = FRAC - k;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_s[k+1]   <= s_s[k];
                deg_s[k+1] <= deg_s[k];
            end
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic signed [AW-1:0] s_ext, d2_try, ds_try;
            logic                 fit;

            always_comb
            begin
                s_ext  = signed'(AW'(s_s[k]));
                d2_try = d2_s[k][l] + (ds_s[k][l] <<< (B + 2)) + (s_ext <<< (2 * B + 2));
                ds_try = ds_s[k][l] + (s_ext <<< (B + 1));
                fit    = d2_try <= r_s[k][l];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d2_s[k+1][l]  <= fit ? d2_try : d2_s[k][l];
                    ds_s[k+1][l]  <= fit ? ds_try : ds_s[k][l];
                    q_s[k+1][l]   <= fit ? (q_s[k][l] | (QW'(1) << B)) : q_s[k][l];
                    r_s[k+1][l]   <= r_s[k][l];
                    neg_s[k+1][l] <= neg_s[k][l];
                end
            end
        end
    end

    // Restore the sign, or give the default axis (0, 0, 1).
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_reg <= deg_s[FRAC+1];
            for (int l = 0; l < 3; l++)
            begin
                if (deg_s[FRAC+1])
                begin
                    axis_reg[l] <= (l == 2) ? signed'(CW'(1) << FRAC) : '0;
                end
                else if (neg_s[FRAC+1][l])
                begin
                    axis_reg[l] <= signed'(CW'(0) - CW'(q_s[FRAC+1][l]));
                end
                else
                begin
                    axis_reg[l] <= signed'(CW'(q_s[FRAC+1][l]));
                end
            end
        end
    end

    assign axis_x     = axis_reg[0];
    assign axis_y     = axis_reg[1];
    assign axis_z     = axis_reg[2];
    assign degenerate = deg_reg;

endmodule

FILE: hw/rtl/q2a_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2a_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "quaternion_to_axis_angle_defines.svh"

module q2a_checker
    import q2a_pkg::*;
#(
    parameter int COMPONENT_WIDTH = CW_DEFAULT
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [((3*COMPONENT_WIDTH+ANGLE_W+7)/8)*8-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    localparam int CW   = COMPONENT_WIDTH;
    localparam int FRAC = CW - 2;
    localparam logic [CW-1:0] AX_ONE = CW'(1) << FRAC;

    logic [CW-1:0] out_x, out_y, out_z;
    angle_t        out_ang;

    assign out_x   = m_axis_tdata[0 +: CW];
    assign out_y   = m_axis_tdata[CW +: CW];
    assign out_z   = m_axis_tdata[2*CW +: CW];
    assign out_ang = m_axis_tdata[3*CW +: ANGLE_W];

    // A result that is not taken holds.
    `Q2A_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // With no result waiting the block must take input.
    `Q2A_ASSERT_IMP(a_ready_free, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")

    // A degenerate result carries the default axis and a zero angle.
    `Q2A_ASSERT_IMP(a_deg_default, m_axis_tvalid && m_axis_tuser, out_x == '0 && out_y == '0 && out_z == AX_ONE && out_ang == '0, "bad degenerate result")

    // The angle never passes two pi.
    `Q2A_ASSERT_IMP(a_angle_range, m_axis_tvalid, out_ang <= angle_t'(ANGLE_MAX), "angle out of range")

endmodule

bind quaternion_to_axis_angle q2a_checker #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_q2a_checker (.*);
